[src/urd_pkg.sv]
// Shared constants, codes and control types of the uniform range decoder.
`default_nettype none

package urd_pkg;

	// Word and digit sizes of the coder.
	localparam int VALUE_BITS = 32;
	localparam int NIBBLE_BITS = 4;
	localparam int BYTE_BITS = 8;
	localparam int FUNC_BITS = 2;

	// Interval thresholds used by renormalisation.
	localparam int HEAD_START_LOG2 = 28;
	localparam int RANGE_LIMIT_LOG2 = 20;
	localparam logic [VALUE_BITS-1:0] HEAD_START = VALUE_BITS'(1) << HEAD_START_LOG2;
	localparam logic [VALUE_BITS-1:0] RANGE_LIMIT_MASK =
		(VALUE_BITS'(1) << RANGE_LIMIT_LOG2) - VALUE_BITS'(1);
	localparam logic [VALUE_BITS-1:0] MIN_BOUND = VALUE_BITS'(2);

	// Upper bound on renormalisation shifts and the width of the step counter.
	localparam int RENORM_CAP = 4 * ((VALUE_BITS + NIBBLE_BITS - 1) / NIBBLE_BITS);
	localparam int STEP_BITS = $clog2(RENORM_CAP + 1);

	// Divider iteration counter width.
	localparam int DIV_STEP_BITS = $clog2(VALUE_BITS);

	// Request function codes.
	typedef enum logic [FUNC_BITS-1:0] {
		FUNC_PUSH   = 2'd0,
		FUNC_START  = 2'd1,
		FUNC_DECODE = 2'd2
	} func_t;

	// Controller states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_POP,
		S_POP_WAIT,
		S_DIV1,
		S_DIV2,
		S_RN_STEP,
		S_RN_WAIT,
		S_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic push;
		logic init;
		logic code_shift;
		logic div1_go;
		logic div1_end;
		logic div2_end;
		logic rn_shift;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [FUNC_BITS-1:0] func;
		logic                 bound_small;
		logic                 div_done;
		logic                 div_zero;
		logic                 rn_stop;
	} sts_t;

endpackage

`default_nettype wire

[src/urd_if.sv]
// Request and result channel interfaces of the uniform range decoder.
`default_nettype none

interface urd_in_if;
	logic                               valid;
	logic                               ready;
	logic [urd_pkg::FUNC_BITS-1:0]      func;
	logic [urd_pkg::BYTE_BITS-1:0]      byte_value;
	logic [urd_pkg::VALUE_BITS-1:0]     max_value;

	modport source (output valid, output func, output byte_value, output max_value,
		input ready);
	modport sink (input valid, input func, input byte_value, input max_value,
		output ready);
endinterface

interface urd_out_if;
	logic                               valid;
	logic                               ready;
	logic [urd_pkg::VALUE_BITS-1:0]     value;
	logic                               healthy;
	logic                               dropped;

	modport source (output valid, output value, output healthy, output dropped,
		input ready);
	modport sink (input valid, input value, input healthy, input dropped,
		output ready);
endinterface

`default_nettype wire

[src/urd_div.sv]
// Restoring divider: one quotient bit per cycle, quotient and remainder held at done.
`default_nettype none

module urd_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           go,
	input  wire logic [urd_pkg::VALUE_BITS-1:0] dividend,
	input  wire logic [urd_pkg::VALUE_BITS-1:0] divisor,
	output logic                                done,
	output logic [urd_pkg::VALUE_BITS-1:0]      quotient,
	output logic [urd_pkg::VALUE_BITS-1:0]      remainder
);

	localparam int VB = urd_pkg::VALUE_BITS;

	logic                               busy_q;
	logic                               done_q;
	logic [urd_pkg::DIV_STEP_BITS-1:0]  cnt_q;
	logic [VB-1:0]                      rem_q;
	logic [VB-1:0]                      quo_q;
	logic [VB-1:0]                      dvs_q;
	logic [VB:0]                        shifted;
	logic [VB:0]                        trial;

	// One trial subtraction of the shifted partial remainder.
	always_comb begin
		shifted = {rem_q, quo_q[VB-1]};
		trial = shifted - {1'b0, dvs_q};
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == urd_pkg::DIV_STEP_BITS'(VB - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[VB]) begin
				rem_q <= trial[VB-1:0];
				quo_q <= {quo_q[VB-2:0], 1'b1};
			end else begin
				rem_q <= shifted[VB-1:0];
				quo_q <= {quo_q[VB-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

[src/urd_dp.sv]
// Datapath: coder interval registers, nibble queue memory, shared divider, result register.
`default_nettype none

module urd_dp #(
	parameter int QUEUE_DEPTH = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire urd_pkg::cmd_t                   cmd,
	output urd_pkg::sts_t                        sts,
	input  wire logic [urd_pkg::FUNC_BITS-1:0]   func,
	input  wire logic [urd_pkg::BYTE_BITS-1:0]   byte_value,
	input  wire logic [urd_pkg::VALUE_BITS-1:0]  max_value,
	output logic [urd_pkg::VALUE_BITS-1:0]       value,
	output logic                                 healthy,
	output logic                                 dropped
);

	localparam int VB = urd_pkg::VALUE_BITS;
	localparam int NB = urd_pkg::NIBBLE_BITS;
	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = PW + 1;

	// Captured request.
	logic [urd_pkg::FUNC_BITS-1:0]  func_q;
	logic [NB-1:0]                  nib_q;
	logic [VB-1:0]                  bound_q;

	// Coder state.
	logic [VB-1:0]                  low_q;
	logic [VB-1:0]                  range_q;
	logic [VB-1:0]                  code_q;
	logic                           healthy_q;
	logic [VB-1:0]                  sym_q;
	logic                           drop_q;

	// Queue state and storage.
	logic [PW-1:0]                  head_q;
	logic [CW-1:0]                  count_q;
	logic [NB-1:0]                  mem [QUEUE_DEPTH];
	logic [NB-1:0]                  rd_q;

	// Result register.
	logic [VB-1:0]                  value_q;
	logic                           healthy_out_q;
	logic                           dropped_q;

	// Divider connections.
	logic                           div_go;
	logic [VB-1:0]                  div_dividend;
	logic [VB-1:0]                  div_divisor;
	logic                           div_done;
	logic [VB-1:0]                  div_quo;
	logic [VB-1:0]                  div_rem;

	// Combinational helpers.
	logic                           q_empty;
	logic                           q_full;
	logic [SW-1:0]                  tail_sum;
	logic [PW-1:0]                  tail;
	logic [PW-1:0]                  head_next;
	logic                           pop_en;
	logic [NB-1:0]                  pop_nib;
	logic [VB-1:0]                  span;
	logic                           crossed;
	logic                           rn_stop;
	logic [VB-1:0]                  range_adj;

	urd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (div_go),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Queue pointers, write position and the nibble taken on a pop.
	always_comb begin
		q_empty = (count_q == '0);
		q_full = (count_q == CW'(QUEUE_DEPTH));
		tail_sum = SW'(head_q) + SW'(count_q);
		if (tail_sum >= SW'(QUEUE_DEPTH)) begin
			tail = PW'(tail_sum - SW'(QUEUE_DEPTH));
		end else begin
			tail = PW'(tail_sum);
		end
		if (head_q == PW'(QUEUE_DEPTH - 1)) begin
			head_next = '0;
		end else begin
			head_next = head_q + 1'b1;
		end
		pop_en = (cmd.code_shift || cmd.rn_shift) && !q_empty;
		pop_nib = q_empty ? '0 : rd_q;
	end

	// Renormalisation test: do the top digits of the interval ends differ?
	always_comb begin
		span = low_q + range_q - VB'(1);
		crossed = ((low_q ^ span) >= urd_pkg::HEAD_START);
		rn_stop = crossed && (range_q > urd_pkg::RANGE_LIMIT_MASK);
		range_adj = crossed ? (VB'(0) - low_q) : range_q;
	end

	// Divider operands: range by bound first, then the code offset by the new range.
	always_comb begin
		div_go = cmd.div1_go || (cmd.div1_end && (div_quo != '0));
		div_dividend = cmd.div1_go ? range_q : (code_q - low_q);
		div_divisor = cmd.div1_go ? bound_q : div_quo;
	end

	// Captured request fields.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			nib_q <= byte_value[NB-1:0];
			bound_q <= max_value;
		end
	end

	// Coder interval, code register and health flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= '0;
			range_q <= '1;
			code_q <= '0;
			healthy_q <= 1'b1;
		end else begin
			if (cmd.init) begin
				low_q <= '0;
				range_q <= '1;
				code_q <= '0;
				healthy_q <= 1'b1;
			end
			if (cmd.code_shift) begin
				code_q <= {code_q[VB-NB-1:0], pop_nib};
			end
			if (cmd.div1_end) begin
				range_q <= div_quo;
				if (div_quo == '0) begin
					healthy_q <= 1'b0;
				end
			end
			if (cmd.div2_end) begin
				if (div_quo > bound_q) begin
					healthy_q <= 1'b0;
				end else begin
					// low + q * range equals code - remainder.
					low_q <= code_q - div_rem;
				end
			end
			if (cmd.rn_shift) begin
				code_q <= {code_q[VB-NB-1:0], pop_nib};
				range_q <= {range_adj[VB-NB-1:0], {NB{1'b1}}};
				low_q <= {low_q[VB-NB-1:0], {NB{1'b0}}};
			end
		end
	end

	// Decoded symbol and drop mark of the current request.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sym_q <= '0;
			drop_q <= 1'b0;
		end
		if (cmd.push && q_full) begin
			drop_q <= 1'b1;
		end
		if (cmd.div2_end && (div_quo <= bound_q)) begin
			sym_q <= div_quo;
		end
	end

	// Queue occupancy and read pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
		end else begin
			if (cmd.push && !q_full) begin
				count_q <= count_q + 1'b1;
			end else if (pop_en) begin
				count_q <= count_q - 1'b1;
				head_q <= head_next;
			end
		end
	end

	// Nibble memory with a registered read at the head.
	always_ff @(posedge clk) begin
		if (cmd.push && !q_full) begin
			mem[tail] <= nib_q;
		end
		rd_q <= mem[head_q];
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			value_q <= sym_q;
			healthy_out_q <= healthy_q;
			dropped_q <= drop_q;
		end
	end

	always_comb begin
		sts.func = func_q;
		sts.bound_small = (bound_q < urd_pkg::MIN_BOUND);
		sts.div_done = div_done;
		sts.div_zero = (div_quo == '0);
		sts.rn_stop = rn_stop;
	end

	assign value = value_q;
	assign healthy = healthy_out_q;
	assign dropped = dropped_q;

endmodule

`default_nettype wire

[src/urd_ctrl.sv]
// Controller: sequences push, start and decode requests and the result handshake.
`default_nettype none

module urd_ctrl #(
	parameter int NUM_NIBBLES = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire urd_pkg::sts_t sts,
	output urd_pkg::cmd_t      cmd
);

	localparam int SB = urd_pkg::STEP_BITS;

	urd_pkg::state_t   state_q;
	urd_pkg::state_t   state_next;
	logic [SB-1:0]     cnt_q;
	logic              out_valid_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= urd_pkg::S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and commands.
	always_comb begin
		state_next = state_q;
		cmd = '0;
		case (state_q)
			urd_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_next = urd_pkg::S_DISPATCH;
				end
			end
			urd_pkg::S_DISPATCH: begin
				case (sts.func)
					urd_pkg::FUNC_PUSH: begin
						cmd.push = 1'b1;
						state_next = urd_pkg::S_FINISH;
					end
					urd_pkg::FUNC_START: begin
						cmd.init = 1'b1;
						state_next = urd_pkg::S_POP;
					end
					urd_pkg::FUNC_DECODE: begin
						if (sts.bound_small) begin
							state_next = urd_pkg::S_FINISH;
						end else begin
							cmd.div1_go = 1'b1;
							state_next = urd_pkg::S_DIV1;
						end
					end
					default: begin
						state_next = urd_pkg::S_FINISH;
					end
				endcase
			end
			urd_pkg::S_POP: begin
				cmd.code_shift = 1'b1;
				state_next = urd_pkg::S_POP_WAIT;
			end
			urd_pkg::S_POP_WAIT: begin
				if (cnt_q == SB'(NUM_NIBBLES)) begin
					state_next = urd_pkg::S_FINISH;
				end else begin
					state_next = urd_pkg::S_POP;
				end
			end
			urd_pkg::S_DIV1: begin
				if (sts.div_done) begin
					cmd.div1_end = 1'b1;
					state_next = sts.div_zero ? urd_pkg::S_RN_STEP : urd_pkg::S_DIV2;
				end
			end
			urd_pkg::S_DIV2: begin
				if (sts.div_done) begin
					cmd.div2_end = 1'b1;
					state_next = urd_pkg::S_RN_STEP;
				end
			end
			urd_pkg::S_RN_STEP: begin
				if ((cnt_q == SB'(urd_pkg::RENORM_CAP)) || sts.rn_stop) begin
					state_next = urd_pkg::S_FINISH;
				end else begin
					cmd.rn_shift = 1'b1;
					state_next = urd_pkg::S_RN_WAIT;
				end
			end
			urd_pkg::S_RN_WAIT: begin
				state_next = urd_pkg::S_RN_STEP;
			end
			urd_pkg::S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_next = urd_pkg::S_IDLE;
				end
			end
			default: begin
				state_next = urd_pkg::S_IDLE;
			end
		endcase
	end

	// Shift counter shared by the start fill and renormalisation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.capture) begin
			cnt_q <= '0;
		end else if (cmd.code_shift || cmd.rn_shift) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_ready = (state_q == urd_pkg::S_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

[src/uniform_range_decoder_top.sv]
// Top level of the nibble-fed uniform range decoder.
//
//   Channel   Direction   Payload                           Per request
//   request   in          func, byte_value, max_value        one request
//   result    out         value, healthy, dropped            one result
//
// One request is worked on at a time; a new request is taken while the previous
// result still waits in the output register.
// Push, invalid and bound-below-two requests bypass the divider; start shifts in NUM_NIBBLES nibbles.
// Decode runs two passes of the shared bit-serial divider, then at most 32 renormalisation
// shifts; a range that divides to zero skips the second pass.
// Reset clears the coder state and the queue occupancy; the queue memory itself
// is not cleared. A stalled result only holds the controller in its final state.
`default_nettype none

module uniform_range_decoder_top #(
	parameter int QUEUE_DEPTH = 64,
	parameter int NUM_NIBBLES = 8
) (
	input wire logic   clk,
	input wire logic   arst_n,
	urd_in_if.sink     request,
	urd_out_if.source  result
);

	urd_pkg::cmd_t  cmd;
	urd_pkg::sts_t  sts;

	urd_ctrl #(
		.NUM_NIBBLES (NUM_NIBBLES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (request.valid),
		.in_ready  (request.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	urd_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.func       (request.func),
		.byte_value (request.byte_value),
		.max_value  (request.max_value),
		.value      (result.value),
		.healthy    (result.healthy),
		.dropped    (result.dropped)
	);

	// A new result is only written when the output register is free.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!result.valid || result.ready))
		else $error("result register overwritten while still pending");

	// Only one request is in work at a time.
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		(request.valid && request.ready) |=> !request.ready)
		else $error("request accepted while another is in work");

	// The divider only finishes while a decode request is in work.
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> !request.ready)
		else $error("divider finished while the block was idle");

endmodule

`default_nettype wire
